### hw/rtl/sdaf_pkg.sv
package sdaf_pkg;

   localparam int WHOLE_BITS      = 31;
   localparam int FRAC_BITS       = 7;
   localparam int WHOLE_DIGITS    = 10;
   localparam int FRAC_BCD_DIGITS = 3;
   localparam int STEP_W          = 5;
   localparam int WIDX_W          = 4;
   localparam int CHAR_W          = 8;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_PLAN,
      ST_SIGN,
      ST_WHOLE,
      ST_POINT,
      ST_FRAC
   } state_type;

   typedef enum logic [1:0] {
      KIND_SIGN,
      KIND_WHOLE,
      KIND_POINT,
      KIND_FRAC
   } char_kind_type;

   typedef struct packed {
      logic                load;
      logic                shift;
      logic                frac_shift;
      logic                emit;
      char_kind_type       kind;
      logic                last;
      logic [WIDX_W-1:0]   widx;
   } ctrl_cmd_type;

   typedef struct packed {
      logic                whole_nz;
      logic                frac_nz;
      logic [WIDX_W-1:0]   top_idx;
      logic                negative;
      logic                with_fraction;
   } dp_status_type;

endpackage

### hw/rtl/sdaf_ctrl.sv
module sdaf_ctrl #(
   parameter int FRAC_DIGITS = 2,
   parameter int FIDX_W      = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  sdaf_pkg::dp_status_type status,
   output sdaf_pkg::ctrl_cmd_type cmd,
   output logic [FIDX_W-1:0]      fidx
);
   import sdaf_pkg::*;

   state_type            state_ff, state_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [WIDX_W-1:0]    widx_ff, widx_in;
   logic [FIDX_W-1:0]    fidx_ff, fidx_in;
   logic                 need_sign;
   logic                 show_whole;

   assign need_sign  = status.negative &
                       (status.whole_nz | (status.with_fraction & status.frac_nz));
   assign show_whole = !status.with_fraction || status.whole_nz;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         widx_ff  <= '0;
         fidx_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         widx_ff  <= widx_in;
         fidx_ff  <= fidx_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_CONVERT;
         end
         ST_CONVERT: begin
            if (step_ff == STEP_W'(WHOLE_BITS - 1)) state_in = ST_PLAN;
         end
         ST_PLAN: begin
            if (need_sign)       state_in = ST_SIGN;
            else if (show_whole) state_in = ST_WHOLE;
            else                 state_in = ST_POINT;
         end
         ST_SIGN: begin
            state_in = show_whole ? ST_WHOLE : ST_POINT;
         end
         ST_WHOLE: begin
            if (widx_ff == '0) state_in = status.with_fraction ? ST_POINT : ST_IDLE;
         end
         ST_POINT: begin
            state_in = ST_FRAC;
         end
         ST_FRAC: begin
            if (fidx_ff == '0) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // counters
   always_comb begin
      step_in = step_ff;
      widx_in = widx_ff;
      fidx_in = fidx_ff;
      unique case (state_ff)
         ST_IDLE:    step_in = '0;
         ST_CONVERT: step_in = step_ff + STEP_W'(1);
         ST_PLAN:    widx_in = status.top_idx;
         ST_WHOLE: begin
            if (widx_ff != '0) widx_in = widx_ff - WIDX_W'(1);
         end
         ST_POINT:   fidx_in = FIDX_W'(FRAC_DIGITS - 1);
         ST_FRAC: begin
            if (fidx_ff != '0) fidx_in = fidx_ff - FIDX_W'(1);
         end
         default: ;
      endcase
   end

   // outputs
   always_comb begin
      cmd            = '0;
      cmd.kind       = KIND_SIGN;
      cmd.widx       = widx_ff;
      unique case (state_ff)
         ST_IDLE:    cmd.load = start;
         ST_CONVERT: begin
            cmd.shift      = 1'b1;
            cmd.frac_shift = (step_ff >= STEP_W'(WHOLE_BITS - FRAC_BITS));
         end
         ST_PLAN: ;
         ST_SIGN: begin
            cmd.emit = 1'b1;
            cmd.kind = KIND_SIGN;
         end
         ST_WHOLE: begin
            cmd.emit = 1'b1;
            cmd.kind = KIND_WHOLE;
            cmd.last = !status.with_fraction && (widx_ff == '0);
         end
         ST_POINT: begin
            cmd.emit = 1'b1;
            cmd.kind = KIND_POINT;
         end
         ST_FRAC: begin
            cmd.emit = 1'b1;
            cmd.kind = KIND_FRAC;
            cmd.last = (fidx_ff == '0);
         end
         default: ;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);
   assign fidx = fidx_ff;

endmodule

### hw/rtl/sdaf_datapath.sv
module sdaf_datapath #(
   parameter int FRAC_DIGITS = 2,
   parameter int FIDX_W      = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_negative,
   input  logic [30:0]            req_whole,
   input  logic [6:0]             req_fraction,
   input  logic                   req_with_fraction,
   input  sdaf_pkg::ctrl_cmd_type cmd,
   input  logic [FIDX_W-1:0]      fidx,
   output sdaf_pkg::dp_status_type status,
   output logic                   rsp_strobe,
   output logic [7:0]             rsp_char_code,
   output logic                   rsp_last
);
   import sdaf_pkg::*;

   localparam int FSEL_N = 2 ** FIDX_W;

   logic [WHOLE_BITS-1:0] whole_sh_ff, whole_sh_in;
   logic [FRAC_BITS-1:0]  frac_sh_ff, frac_sh_in;
   logic [3:0]            whole_bcd_ff [WHOLE_DIGITS];
   logic [3:0]            whole_bcd_in [WHOLE_DIGITS];
   logic [3:0]            frac_bcd_ff  [FRAC_BCD_DIGITS];
   logic [3:0]            frac_bcd_in  [FRAC_BCD_DIGITS];
   logic [3:0]            whole_adj    [WHOLE_DIGITS];
   logic [3:0]            frac_adj     [FRAC_BCD_DIGITS];
   logic [3:0]            frac_dig     [FSEL_N];
   logic                  neg_ff, wf_ff;
   logic                  strobe_ff;
   logic [CHAR_W-1:0]     char_ff, char_in;
   logic                  last_ff;
   logic                  frac_bit;

   // double dabble: add 3 to digits of 5 or more, then shift one bit in
   always_comb begin
      for (int i = 0; i < WHOLE_DIGITS; i++) begin
         whole_adj[i] = (whole_bcd_ff[i] >= 4'd5) ? whole_bcd_ff[i] + 4'd3 : whole_bcd_ff[i];
      end
      for (int i = 0; i < FRAC_BCD_DIGITS; i++) begin
         frac_adj[i] = (frac_bcd_ff[i] >= 4'd5) ? frac_bcd_ff[i] + 4'd3 : frac_bcd_ff[i];
      end
      // fraction is right-aligned in the shift window, so zeros go in first
      frac_bit = cmd.frac_shift & frac_sh_ff[FRAC_BITS-1];

      whole_sh_in = whole_sh_ff;
      frac_sh_in  = frac_sh_ff;
      whole_bcd_in = whole_bcd_ff;
      frac_bcd_in  = frac_bcd_ff;
      if (cmd.load) begin
         whole_sh_in = req_whole;
         frac_sh_in  = req_fraction;
         for (int i = 0; i < WHOLE_DIGITS; i++) whole_bcd_in[i] = '0;
         for (int i = 0; i < FRAC_BCD_DIGITS; i++) frac_bcd_in[i] = '0;
      end else if (cmd.shift) begin
         whole_sh_in = {whole_sh_ff[WHOLE_BITS-2:0], 1'b0};
         if (cmd.frac_shift) frac_sh_in = {frac_sh_ff[FRAC_BITS-2:0], 1'b0};
         whole_bcd_in[0] = {whole_adj[0][2:0], whole_sh_ff[WHOLE_BITS-1]};
         for (int i = 1; i < WHOLE_DIGITS; i++) begin
            whole_bcd_in[i] = {whole_adj[i][2:0], whole_adj[i-1][3]};
         end
         frac_bcd_in[0] = {frac_adj[0][2:0], frac_bit};
         for (int i = 1; i < FRAC_BCD_DIGITS; i++) begin
            frac_bcd_in[i] = {frac_adj[i][2:0], frac_adj[i-1][3]};
         end
      end
   end

   always_ff @(posedge clock) begin
      whole_sh_ff  <= whole_sh_in;
      frac_sh_ff   <= frac_sh_in;
      whole_bcd_ff <= whole_bcd_in;
      frac_bcd_ff  <= frac_bcd_in;
      if (cmd.load) begin
         neg_ff <= req_negative;
         wf_ff  <= req_with_fraction;
      end
   end

   // fraction digits modulo 10^FRAC_DIGITS; positions past the BCD width are zero
   always_comb begin
      for (int p = 0; p < FSEL_N; p++) begin
         frac_dig[p] = '0;
         if (p < FRAC_BCD_DIGITS && p < FRAC_DIGITS) frac_dig[p] = frac_bcd_ff[p];
      end
      status.frac_nz = 1'b0;
      for (int p = 0; p < FSEL_N; p++) begin
         if (frac_dig[p] != '0) status.frac_nz = 1'b1;
      end
      status.whole_nz = 1'b0;
      status.top_idx  = '0;
      for (int i = 0; i < WHOLE_DIGITS; i++) begin
         if (whole_bcd_ff[i] != '0) begin
            status.whole_nz = 1'b1;
            status.top_idx  = WIDX_W'(i);
         end
      end
      status.negative      = neg_ff;
      status.with_fraction = wf_ff;
   end

   always_comb begin
      unique case (cmd.kind)
         KIND_SIGN:  char_in = CHAR_MINUS;
         KIND_WHOLE: char_in = CHAR_ZERO + {4'b0, whole_bcd_ff[cmd.widx]};
         KIND_POINT: char_in = CHAR_POINT;
         KIND_FRAC:  char_in = CHAR_ZERO + {4'b0, frac_dig[fidx]};
         default:    char_in = CHAR_ZERO;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         char_ff <= char_in;
         last_ff <= cmd.last;
      end
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_char_code = char_ff;
   assign rsp_last      = last_ff;

endmodule

### hw/rtl/signed_decimal_ascii_formatter.sv
// Signed decimal ASCII formatter.
// Input: pulse start with req_negative, req_whole, req_fraction and
// req_with_fraction valid; the number is taken when start is high and busy
// is low. busy stays high until the last character has been issued.
// Output: one ASCII character per rsp_strobe cycle, most significant first,
// rsp_last marking the final character. Characters come on consecutive
// cycles and are not held: the receiver must take each one as it appears.
// Sequence: binary to BCD shifting (one bit per cycle through the double
// dabble registers), a planning state, then the characters, of which a
// number has up to 12 + FRAC_DIGITS. A new number can be taken the cycle
// busy drops, which is the cycle the last character is on the output.
// The fraction is reduced modulo 10^FRAC_DIGITS. Reset returns the
// sequencer to idle and clears the strobe; no characters are pending after.
module signed_decimal_ascii_formatter #(
   parameter int FRAC_DIGITS = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_negative,
   input  logic [30:0] req_whole,
   input  logic [6:0]  req_fraction,
   input  logic        req_with_fraction,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_char_code,
   output logic        rsp_last
);
   import sdaf_pkg::*;

   localparam int FIDX_W = (FRAC_DIGITS > 1) ? $clog2(FRAC_DIGITS) : 1;

   ctrl_cmd_type        cmd;
   dp_status_type       status;
   logic [FIDX_W-1:0]   fidx;

   sdaf_ctrl #(
      .FRAC_DIGITS (FRAC_DIGITS),
      .FIDX_W      (FIDX_W)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd),
      .fidx   (fidx)
   );

   sdaf_datapath #(
      .FRAC_DIGITS (FRAC_DIGITS),
      .FIDX_W      (FIDX_W)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_negative      (req_negative),
      .req_whole         (req_whole),
      .req_fraction      (req_fraction),
      .req_with_fraction (req_with_fraction),
      .cmd               (cmd),
      .fidx              (fidx),
      .status            (status),
      .rsp_strobe        (rsp_strobe),
      .rsp_char_code     (rsp_char_code),
      .rsp_last          (rsp_last)
   );

endmodule

### hw/rtl/sdaf_checker.sv
module sdaf_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_strobe,
   input logic       rsp_last
);

   // a transfer starts a conversion
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not set after transfer");

   // conversion phase follows a transfer, so no character right after it
   a_start_quiet: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_strobe)
      else $error("character right after transfer");

   // characters of one number are contiguous
   a_contig: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |=> rsp_strobe)
      else $error("gap inside a number");

   // the final character coincides with busy having dropped
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |-> !busy)
      else $error("busy high on final character");

   a_fell_last: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> (rsp_strobe && rsp_last))
      else $error("busy dropped without final character");

endmodule

bind signed_decimal_ascii_formatter sdaf_checker u_sdaf_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_strobe    (rsp_strobe),
   .rsp_last      (rsp_last)
);
